// ----- sv/sbsw_pkg.sv -----
// Shared constants, register indexes and bus layouts for the slotted broadcast scheduler.
`default_nettype none

package sbsw_pkg;

    localparam int unsigned NOW_W       = 32;
    localparam int unsigned STATIONS    = 4;
    localparam int unsigned STATION_W   = 2;
    localparam int unsigned PERIOD_W    = 29;
    localparam int unsigned CFG_DATA_W  = 29;

    localparam int unsigned REPLY_QUORUM    = 3;
    localparam int unsigned TIMEOUT_SHIFT   = 3;   // timeout = 8 periods
    localparam int unsigned SLOT_SHIFT      = 2;   // slot = period / 4
    localparam int unsigned SLOT_W          = PERIOD_W - SLOT_SHIFT;

    localparam logic [PERIOD_W-1:0]  POLL_PERIOD_RESET = PERIOD_W'(5000);
    localparam logic [STATION_W-1:0] MASTER_ID         = '0;

    // input tdata: now, reply_flags, sync_seen, zero padding to 40 bits
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned IN_USED_W  = NOW_W + STATIONS + 1;
    // output tdata: send_sync, send_status, link_fault, padding to 8 bits
    localparam int unsigned OUT_DATA_W = 8;

    typedef enum logic [0:0] {
        REG_STATION_ID  = 1'b0,
        REG_POLL_PERIOD = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic                sync_seen;
        logic [STATIONS-1:0] reply_flags;
        logic [NOW_W-1:0]    now;
    } in_item_t;

    typedef struct packed {
        logic link_fault;
        logic send_status;
        logic send_sync;
    } out_item_t;

endpackage

`default_nettype wire

// ----- sv/slotted_broadcast_scheduler_watchdog.sv -----
// Top level of the slotted broadcast scheduler with network watchdog.
//
// Each request on s_axis is one handler call and yields exactly one result on
// m_axis, in order. A request is captured in an input register, the schedule
// and watchdog decisions are made combinationally by compares and subtracts
// against the stamps, and the result sits in an output register. One request
// is taken every cycle while the channel does not stall; a result moves from
// the input register to the output register and shows on m_axis from there.
// The input register can take a request while a result waits on m_axis, so
// the channel stalls only when both are full.
// Configuration writes are registered and are meant for an idle block.
`default_nettype none

module slotted_broadcast_scheduler_watchdog (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // s_axis_tdata: [31:0] now, [35:32] reply_flags, [36] sync_seen, [39:37] zero
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [sbsw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // m_axis_tdata: [0] send_sync, [1] send_status, [2] link_fault, [7:3] zero
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [sbsw_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [0:0]                          cfg_index,
    input  wire logic [sbsw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // configuration
    logic [sbsw_pkg::STATION_W-1:0] station_id_reg;
    logic [sbsw_pkg::PERIOD_W-1:0]  poll_period_reg;

    // handshake stages
    logic                 in_valid_reg;
    sbsw_pkg::in_item_t   in_item_reg;
    logic                 out_valid_reg;
    sbsw_pkg::out_item_t  out_item_reg;

    // scheduler state
    logic [sbsw_pkg::STATIONS-1:0] pending_reg, pending_next;
    logic [sbsw_pkg::NOW_W-1:0]    health_stamp_reg, health_stamp_next;
    logic [sbsw_pkg::NOW_W-1:0]    poll_stamp_reg, poll_stamp_next;
    logic                          slot_idle_reg, slot_idle_next;
    logic [sbsw_pkg::NOW_W-1:0]    slot_stamp_reg, slot_stamp_next;

    logic                          out_free;
    logic                          advance;
    logic                          in_take;
    sbsw_pkg::out_item_t           result;

    logic [sbsw_pkg::NOW_W-1:0]     poll_diff;
    logic [sbsw_pkg::NOW_W-1:0]     slot_diff;
    logic [sbsw_pkg::NOW_W-1:0]     health_diff;
    logic [sbsw_pkg::SLOT_W-1:0]    slot_unit;
    logic [sbsw_pkg::PERIOD_W-1:0]  slot_len;
    logic [sbsw_pkg::NOW_W-1:0]     timeout;
    logic [sbsw_pkg::STATIONS-1:0]  merged;
    logic                           refresh;
    logic                           is_master;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(sbsw_pkg::OUT_DATA_W - 3){1'b0}}, out_item_reg};

    always_comb
    begin
        is_master = (station_id_reg == sbsw_pkg::MASTER_ID);
        slot_unit = poll_period_reg[sbsw_pkg::PERIOD_W-1:sbsw_pkg::SLOT_SHIFT];
        // slot unit times station id, id is two bits: shift-and-add
        slot_len  = (station_id_reg[0] ? {2'b00, slot_unit} : '0)
                  + (station_id_reg[1] ? {1'b0, slot_unit, 1'b0} : '0);
        timeout   = {poll_period_reg, {sbsw_pkg::TIMEOUT_SHIFT{1'b0}}};

        poll_diff   = in_item_reg.now - poll_stamp_reg;
        slot_diff   = in_item_reg.now - slot_stamp_reg;

        result            = '0;
        poll_stamp_next   = poll_stamp_reg;
        slot_idle_next    = slot_idle_reg;
        slot_stamp_next   = slot_stamp_reg;

        if (is_master)
        begin
            if (poll_diff > {3'b000, poll_period_reg})
            begin
                poll_stamp_next    = in_item_reg.now;
                result.send_sync   = 1'b1;
                result.send_status = 1'b1;
            end
        end
        else
        begin
            if (in_item_reg.sync_seen)
            begin
                // fresh sync re-arms; elapsed time is zero so no fire this call
                slot_idle_next  = 1'b0;
                slot_stamp_next = in_item_reg.now;
            end
            else if (!slot_idle_reg && (slot_diff > {3'b000, slot_len}))
            begin
                slot_idle_next     = 1'b1;
                result.send_status = 1'b1;
            end
        end

        merged  = pending_reg | in_item_reg.reply_flags;
        refresh = ($countones(merged) >= sbsw_pkg::REPLY_QUORUM);
        if (refresh)
        begin
            pending_next      = '0;
            health_stamp_next = in_item_reg.now;
        end
        else
        begin
            pending_next      = merged;
            health_stamp_next = health_stamp_reg;
        end
        health_diff       = in_item_reg.now - health_stamp_reg;
        result.link_fault = !refresh && (health_diff > timeout);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_id_reg   <= '0;
            poll_period_reg  <= sbsw_pkg::POLL_PERIOD_RESET;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            pending_reg      <= '0;
            health_stamp_reg <= '0;
            poll_stamp_reg   <= '0;
            slot_idle_reg    <= 1'b1;
            slot_stamp_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (sbsw_pkg::reg_index_t'(cfg_index))
                    sbsw_pkg::REG_STATION_ID:
                        station_id_reg <= cfg_data[sbsw_pkg::STATION_W-1:0];
                    sbsw_pkg::REG_POLL_PERIOD:
                        poll_period_reg <= cfg_data[sbsw_pkg::PERIOD_W-1:0];
                    default:
                        station_id_reg <= station_id_reg;
                endcase
            end

            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                pending_reg      <= pending_next;
                health_stamp_reg <= health_stamp_next;
                poll_stamp_reg   <= poll_stamp_next;
                slot_idle_reg    <= slot_idle_next;
                slot_stamp_reg   <= slot_stamp_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_item_reg <= sbsw_pkg::in_item_t'(s_axis_tdata[sbsw_pkg::IN_USED_W-1:0]);
        if (advance)
            out_item_reg <= result;
    end

endmodule

`default_nettype wire

// ----- sv/sbsw_checker.sv -----
// Port-level checker for the slotted broadcast scheduler, bound to the top level.
`default_nettype none

module sbsw_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [sbsw_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // sync is only ever sent together with a status broadcast
    a_sync_with_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
        else $error("send_sync without send_status");

    // input side backs up only when a result is waiting
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // a fresh result follows an accepted request
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without accepted request");

endmodule

bind slotted_broadcast_scheduler_watchdog sbsw_checker u_sbsw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- dv/slotted_broadcast_scheduler_watchdog_test.sv -----
// Self-checking testbench for the slotted broadcast scheduler with network watchdog.
`timescale 1ns / 100ps

module slotted_broadcast_scheduler_watchdog_test;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned TARGET_CALLS = 1900;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam logic [sbsw_pkg::PERIOD_W-1:0] PERIOD_MAX = '1;

    // Tracks the schedule and watchdog decisions expected for each accepted call.
    class slot_schedule_board;
        logic [sbsw_pkg::STATION_W-1:0] station;
        logic [sbsw_pkg::PERIOD_W-1:0]  period;
        logic [sbsw_pkg::STATIONS-1:0]  replies;
        logic [sbsw_pkg::NOW_W-1:0]     health_t;
        logic [sbsw_pkg::NOW_W-1:0]     poll_t;
        logic [sbsw_pkg::NOW_W-1:0]     slot_t;
        bit                             slot_idle;
        sbsw_pkg::out_item_t            due_decisions[$];
        int unsigned                    calls;
        int unsigned                    results;
        int unsigned                    errors;
        int unsigned                    n_sync;
        int unsigned                    n_status;
        int unsigned                    n_neterr;

        function new();
            station   = '0;
            period    = sbsw_pkg::POLL_PERIOD_RESET;
            replies   = '0;
            health_t  = '0;
            poll_t    = '0;
            slot_t    = '0;
            slot_idle = 1'b1;
            calls     = 0;
            results   = 0;
            errors    = 0;
            n_sync    = 0;
            n_status  = 0;
            n_neterr  = 0;
        endfunction

        function void write_reg(sbsw_pkg::reg_index_t idx,
                                logic [sbsw_pkg::CFG_DATA_W-1:0] val);
            if (idx == sbsw_pkg::REG_STATION_ID)
                station = val[sbsw_pkg::STATION_W-1:0];
            else
                period = val[sbsw_pkg::PERIOD_W-1:0];
        endfunction

        function void note_call(sbsw_pkg::in_item_t it);
            sbsw_pkg::out_item_t          want;
            logic [sbsw_pkg::NOW_W-1:0]   slot_len;
            logic [sbsw_pkg::NOW_W-1:0]   dt;
            logic [sbsw_pkg::NOW_W+2:0]   timeout;
            want = '0;
            if (station == sbsw_pkg::MASTER_ID)
            begin
                dt = it.now - poll_t;
                if (dt > (sbsw_pkg::NOW_W)'(period))
                begin
                    poll_t           = it.now;
                    want.send_sync   = 1'b1;
                    want.send_status = 1'b1;
                end
            end
            else
            begin
                slot_len = ((sbsw_pkg::NOW_W)'(period) >> sbsw_pkg::SLOT_SHIFT)
                         * (sbsw_pkg::NOW_W)'(station);
                if (it.sync_seen)
                begin
                    slot_idle = 1'b0;
                    slot_t    = it.now;
                end
                dt = it.now - slot_t;
                if (!slot_idle && dt > slot_len)
                begin
                    slot_idle        = 1'b1;
                    want.send_status = 1'b1;
                end
            end
            // refresh is evaluated before the timeout compare
            replies = replies | it.reply_flags;
            if ($countones(replies) >= sbsw_pkg::REPLY_QUORUM)
            begin
                health_t = it.now;
                replies  = '0;
            end
            timeout = (sbsw_pkg::NOW_W+3)'(period) << sbsw_pkg::TIMEOUT_SHIFT;
            dt = it.now - health_t;
            want.link_fault = ((sbsw_pkg::NOW_W+3)'(dt) > timeout);
            n_sync   += want.send_sync;
            n_status += want.send_status;
            n_neterr += want.link_fault;
            calls++;
            due_decisions.push_back(want);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH result %0d: %s", results, msg);
            errors++;
        endtask

        task check_decision(sbsw_pkg::out_item_t got);
            sbsw_pkg::out_item_t want;
            if (due_decisions.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %b", got));
                results++;
                return;
            end
            want = due_decisions.pop_front();
            if (got.send_sync !== want.send_sync)
                report_mismatch($sformatf("send_sync %b, want %b",
                                          got.send_sync, want.send_sync));
            if (got.send_status !== want.send_status)
                report_mismatch($sformatf("send_status %b, want %b",
                                          got.send_status, want.send_status));
            if (got.link_fault !== want.link_fault)
                report_mismatch($sformatf("link_fault %b, want %b",
                                          got.link_fault, want.link_fault));
            results++;
        endtask
    endclass

    logic                              clk           = 1'b0;
    logic                              rst_n         = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [sbsw_pkg::IN_DATA_W-1:0]    s_axis_tdata  = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b1;
    logic [sbsw_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
    logic                              cfg_valid     = 1'b0;
    logic                              cfg_ready;
    logic [0:0]                        cfg_index     = '0;
    logic [sbsw_pkg::CFG_DATA_W-1:0]   cfg_data      = '0;

    slot_schedule_board          board = new();
    int unsigned                 cycles     = 0;
    int unsigned                 stall_left = 0;
    int unsigned                 stall_mode = 0;
    int unsigned                 phases     = 0;
    logic [sbsw_pkg::NOW_W-1:0]  tick_now   = '0;

    slotted_broadcast_scheduler_watchdog u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d requests still due",
                     cycles, board.due_decisions.size());
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_decision(sbsw_pkg::out_item_t'(m_axis_tdata[2:0]));
    end

    // receiver backpressure under a stall mode that is reshuffled at random
    always @(negedge clk)
    begin
        if (cycles % 300 == 0)
            stall_mode = $urandom_range(0, 2);
        if (stall_left != 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if ((stall_mode == 1 && $urandom_range(0, 99) < 10) ||
                 (stall_mode == 2 && $urandom_range(0, 99) < 30))
        begin
            stall_left = $urandom_range(0, stall_mode == 1 ? 2 : 9);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_call(input sbsw_pkg::in_item_t it);
        s_axis_tdata  <= (sbsw_pkg::IN_DATA_W)'(it);
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        board.note_call(it);
        @(negedge clk);
    endtask

    task automatic issue_call(input logic [sbsw_pkg::NOW_W-1:0] t,
                              input logic [sbsw_pkg::STATIONS-1:0] f,
                              input logic s);
        sbsw_pkg::in_item_t it;
        it.now         = t;
        it.reply_flags = f;
        it.sync_seen   = s;
        send_call(it);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (board.due_decisions.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input sbsw_pkg::reg_index_t idx,
                             input logic [sbsw_pkg::CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic apply_config(input logic [sbsw_pkg::STATION_W-1:0] id,
                                input logic [sbsw_pkg::PERIOD_W-1:0] per);
        wait_idle();
        write_reg(sbsw_pkg::REG_STATION_ID, (sbsw_pkg::CFG_DATA_W)'(id));
        write_reg(sbsw_pkg::REG_POLL_PERIOD, (sbsw_pkg::CFG_DATA_W)'(per));
        cfg_valid <= 1'b0;
        phases++;
    endtask

    task automatic run_phase(input int unsigned n_items);
        int unsigned         step_max;
        int unsigned         density;
        int unsigned         sync_pct;
        int unsigned         burst;
        int unsigned         r;
        bit                  gappy;
        sbsw_pkg::in_item_t  it;
        step_max = (board.period < 9) ? 3 : board.period / 3;
        case ($urandom_range(0, 3))
            0:       density = 0;
            1:       density = 5;
            2:       density = 30;
            default: density = 70;
        endcase
        sync_pct = (board.station == sbsw_pkg::MASTER_ID) ? 5 : 12;
        gappy    = $urandom_range(0, 3) != 0;
        burst    = $urandom_range(1, 12);
        for (int unsigned i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                tick_now = $urandom();
            else if (r >= 10)
                tick_now = tick_now + $urandom_range(0, step_max);
            it.now         = tick_now;
            it.reply_flags = ($urandom_range(0, 99) < density)
                           ? (sbsw_pkg::STATIONS)'($urandom_range(1, 15)) : '0;
            it.sync_seen   = $urandom_range(0, 99) < sync_pct;
            send_call(it);
            if (gappy)
            begin
                burst--;
                if (burst == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(negedge clk);
                    burst = $urandom_range(1, 12);
                end
            end
        end
    endtask

    initial
    begin
        logic [sbsw_pkg::STATION_W-1:0] id;
        logic [sbsw_pkg::PERIOD_W-1:0]  per;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: master, period 5000
        issue_call(0, 4'b0000, 1'b0);
        issue_call(5000, 4'b0000, 1'b0);
        issue_call(5001, 4'b0000, 1'b0);
        issue_call(5001, 4'b0011, 1'b1);       // master ignores sync
        issue_call(5002, 4'b0100, 1'b0);       // quorum reached
        issue_call(45003, 4'b0000, 1'b0);      // just past eight periods
        issue_call(45003, 4'b1111, 1'b0);      // refresh clears error on same call

        // zero period on the master
        apply_config(0, 0);
        issue_call(45003, 4'b0000, 1'b0);
        issue_call(45004, 4'b1000, 1'b0);

        // last slave, widest period; timeout sits just below 2^32
        apply_config(3, PERIOD_MAX);
        issue_call(100, 4'b0000, 1'b1);
        issue_call(100 + 402653181, 4'b0000, 1'b0);
        issue_call(100 + 402653182, 4'b0000, 1'b0);
        issue_call(32'hFFFF_FFFF, 4'b0000, 1'b0);
        issue_call(45002, 4'b0000, 1'b0);
        issue_call(44996, 4'b0000, 1'b0);
        issue_call(44997, 4'b0000, 1'b0);

        // zero period on a slave
        apply_config(1, 0);
        issue_call(7, 4'b0000, 1'b1);
        issue_call(8, 4'b0111, 1'b0);

        // sync while armed re-arms the slot
        apply_config(2, 400);
        issue_call(1000, 4'b0000, 1'b1);
        issue_call(1150, 4'b0000, 1'b1);
        issue_call(1201, 4'b0000, 1'b0);
        issue_call(1351, 4'b0000, 1'b0);

        while (board.calls < TARGET_CALLS)
        begin
            id = (sbsw_pkg::STATION_W)'($urandom_range(0, 3));
            case ($urandom_range(0, 11))
                0:       per = 1;
                1:       per = PERIOD_MAX;
                2:       per = (sbsw_pkg::PERIOD_W)'($urandom());
                3:       per = 0;
                default: per = (sbsw_pkg::PERIOD_W)'($urandom_range(4, 300));
            endcase
            apply_config(id, per);
            run_phase($urandom_range(100, 220));
        end

        wait_idle();
        repeat (8) @(posedge clk);
        $display("covered %0d calls in %0d settings: %0d syncs, %0d status slots, %0d net errors",
                 board.calls, phases, board.n_sync, board.n_status, board.n_neterr);
        $display("checked %0d results, %0d mismatches", board.results, board.errors);
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
